[hw/rtl/lcbf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcbf_pkg: shared definitions for the line-counting byte FIFO
// Word widths, operation and status codes, and the command word that passes
// from the front end to the back end.
// ----------------------------------------------------------------------------
package lcbf_pkg;

    localparam int OPC_W  = 2;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 7;
    localparam int STAT_W = 3;
    localparam int LVL_W  = 10;

    localparam int STORE_SLOTS_DEF = 1024;
    localparam int MAX_BURST_DEF   = 64;

    localparam logic [OPC_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPC_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPC_W-1:0] OP_LINE  = 2'd2;

    localparam logic [STAT_W-1:0] ST_GIVEN   = 3'd0;
    localparam logic [STAT_W-1:0] ST_WR_OK   = 3'd1;
    localparam logic [STAT_W-1:0] ST_WR_FULL = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_LINE = 3'd4;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

    // One classified operation, count already limited to the burst size.
    typedef struct packed {
        logic [OPC_W-1:0]  op;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } cmd_t;

endpackage
`default_nettype wire

[hw/rtl/lcbf_channels.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcbf channels: request and response handshake interfaces
// Each carries valid, ready and the payload of one word.
// ----------------------------------------------------------------------------
interface lcbf_req_if;
    import lcbf_pkg::*;

    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic [BYTE_W-1:0] write_byte;
    logic [CNT_W-1:0]  count;

    modport source (output valid, output opcode, output write_byte, output count,
                    input ready);
    modport sink   (input valid, input opcode, input write_byte, input count,
                    output ready);
endinterface

interface lcbf_rsp_if;
    import lcbf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_byte;
    logic [STAT_W-1:0] status;
    logic              last;
    logic              line_taken;
    logic [LVL_W-1:0]  fill_level;
    logic [LVL_W-1:0]  lines_held;

    modport source (output valid, output read_byte, output status, output last,
                    output line_taken, output fill_level, output lines_held,
                    input ready);
    modport sink   (input valid, input read_byte, input status, input last,
                    input line_taken, input fill_level, input lines_held,
                    output ready);
endinterface
`default_nettype wire

[hw/rtl/lcbf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcbf_front: request decode
// Accepts request words, drops those that produce no result and limits the
// count to the burst size before handing the command to the queue.
// ----------------------------------------------------------------------------
module lcbf_front #(
    parameter int MAX_BURST = lcbf_pkg::MAX_BURST_DEF
) (
    lcbf_req_if.sink         req,
    input  logic             q_full,
    output logic             q_push,
    output lcbf_pkg::cmd_t   q_cmd
);
    import lcbf_pkg::*;

    localparam logic [CNT_W-1:0] BURST_LIM = CNT_W'(MAX_BURST);

    logic keep;

    assign req.ready = !q_full;

    // Reserved opcodes and zero-length reads give nothing and are dropped here.
    always_comb
    begin
        case (req.opcode)
            OP_WRITE: keep = 1'b1;
            OP_READ:  keep = (req.count != '0);
            OP_LINE:  keep = (req.count != '0);
            default:  keep = 1'b0;
        endcase
    end

    assign q_push      = req.valid && !q_full && keep;
    assign q_cmd.op    = req.opcode;
    assign q_cmd.data  = req.write_byte;
    assign q_cmd.count = (req.count > BURST_LIM) ? BURST_LIM : req.count;

endmodule
`default_nettype wire

[hw/rtl/lcbf_cmd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcbf_cmd_queue: two-entry command queue
// Decouples request decode from the store sequencer.
// ----------------------------------------------------------------------------
module lcbf_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lcbf_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output lcbf_pkg::cmd_t head_cmd
);
    import lcbf_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] used_reg, used_next;
    logic       do_push, do_pop;

    assign full       = (used_reg == 2'd2);
    assign head_valid = (used_reg != 2'd0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        used_next   = used_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            used_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            used_reg   <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/lcbf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcbf_back: byte store and sequencer
// Holds the circular byte store, the positions and the newline count, and
// steps through reads one byte per cycle while the response register is free.
// ----------------------------------------------------------------------------
module lcbf_back #(
    parameter int STORE_SLOTS = lcbf_pkg::STORE_SLOTS_DEF,
    parameter int MAX_BURST   = lcbf_pkg::MAX_BURST_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  lcbf_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    lcbf_rsp_if.source      rsp
);
    import lcbf_pkg::*;

    localparam int PW   = $clog2(STORE_SLOTS);
    localparam int RW   = $clog2(MAX_BURST + 1) < 1 ? 1 : $clog2(MAX_BURST + 1);
    localparam int CMPW = PW > RW ? PW : RW;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [PW-1:0]   wpos_reg, wpos_next;
    logic [PW-1:0]   rpos_reg, rpos_next;
    logic [PW-1:0]   nl_reg, nl_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [RW-1:0]   remain_reg, remain_next;
    logic            line_mode_reg, line_mode_next;

    logic [BYTE_W-1:0] mem [STORE_SLOTS];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              mem_we;
    logic              rd_en;
    logic [PW-1:0]     rd_addr;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [STAT_W-1:0] out_stat_reg, out_stat_next;
    logic              out_last_reg, out_last_next;
    logic              out_taken_reg, out_taken_next;
    logic [LVL_W-1:0]  out_fill_reg, out_fill_next;
    logic [LVL_W-1:0]  out_lines_reg, out_lines_next;
    logic              emit;
    logic              out_free;

    logic [PW-1:0] fill;
    logic [PW-1:0] pos_inc;
    logic [RW-1:0] cnt_r;
    logic [RW-1:0] burst_n;
    logic          done;

    assign fill     = wpos_reg - rpos_reg;
    assign pos_inc  = pos_reg + PW'(1);
    assign out_free = !out_valid_reg || rsp.ready;
    assign cnt_r    = RW'(cmd.count);
    assign burst_n  = (CMPW'(fill) < CMPW'(cnt_r)) ? RW'(fill) : cnt_r;

    always_comb
    begin
        state_next     = state_reg;
        wpos_next      = wpos_reg;
        rpos_next      = rpos_reg;
        nl_next        = nl_reg;
        pos_next       = pos_reg;
        remain_next    = remain_reg;
        line_mode_next = line_mode_reg;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = pos_inc;
        cmd_pop        = 1'b0;
        emit           = 1'b0;
        done           = 1'b0;
        out_byte_next  = '0;
        out_stat_next  = ST_GIVEN;
        out_last_next  = 1'b1;
        out_taken_next = 1'b0;
        out_fill_next  = LVL_W'(fill);
        out_lines_next = LVL_W'(nl_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_WRITE:
                        begin
                            emit = 1'b1;
                            if (&fill)
                            begin
                                out_stat_next = ST_WR_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                wpos_next = wpos_reg + PW'(1);
                                if (cmd.data == NEWLINE_BYTE)
                                begin
                                    nl_next = nl_reg + PW'(1);
                                end
                                out_stat_next  = ST_WR_OK;
                                out_fill_next  = LVL_W'(fill + PW'(1));
                                out_lines_next = LVL_W'(nl_next);
                            end
                        end
                        OP_READ, OP_LINE:
                        begin
                            if (fill == '0)
                            begin
                                emit          = 1'b1;
                                out_stat_next = ST_EMPTY;
                                if (cmd.op == OP_LINE)
                                begin
                                    out_stat_next = ST_NO_LINE;
                                end
                            end
                            else if (cmd.op == OP_LINE && nl_reg == '0)
                            begin
                                emit          = 1'b1;
                                out_stat_next = ST_NO_LINE;
                            end
                            else
                            begin
                                rd_en          = 1'b1;
                                rd_addr        = rpos_reg;
                                pos_next       = rpos_reg;
                                remain_next    = burst_n;
                                line_mode_next = (cmd.op == OP_LINE);
                                state_next     = S_EMIT;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_byte_next = rd_data_reg;
                    pos_next      = pos_inc;
                    remain_next   = remain_reg - RW'(1);
                    done          = (remain_reg == RW'(1));
                    out_last_next = done;
                    if (!line_mode_reg)
                    begin
                        // Plain read: every byte is popped as it goes out.
                        rpos_next = pos_inc;
                        if (rd_data_reg == NEWLINE_BYTE && nl_reg != '0)
                        begin
                            nl_next = nl_reg - PW'(1);
                        end
                        out_fill_next  = LVL_W'(wpos_reg - pos_inc);
                        out_lines_next = LVL_W'(nl_next);
                    end
                    else if (rd_data_reg == NEWLINE_BYTE)
                    begin
                        // Line found: commit the pop through the newline.
                        rpos_next      = pos_inc;
                        nl_next        = nl_reg - PW'(1);
                        done           = 1'b1;
                        out_last_next  = 1'b1;
                        out_taken_next = 1'b1;
                        out_fill_next  = LVL_W'(wpos_reg - pos_inc);
                        out_lines_next = LVL_W'(nl_next);
                    end
                    if (done)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wpos_reg      <= '0;
            rpos_reg      <= '0;
            nl_reg        <= '0;
            pos_reg       <= '0;
            remain_reg    <= '0;
            line_mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wpos_reg      <= wpos_next;
            rpos_reg      <= rpos_next;
            nl_reg        <= nl_next;
            pos_reg       <= pos_next;
            remain_reg    <= remain_next;
            line_mode_reg <= line_mode_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg  <= out_byte_next;
            out_stat_reg  <= out_stat_next;
            out_last_reg  <= out_last_next;
            out_taken_reg <= out_taken_next;
            out_fill_reg  <= out_fill_next;
            out_lines_reg <= out_lines_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wpos_reg] <= cmd.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_byte  = out_byte_reg;
    assign rsp.status     = out_stat_reg;
    assign rsp.last       = out_last_reg;
    assign rsp.line_taken = out_taken_reg;
    assign rsp.fill_level = out_fill_reg;
    assign rsp.lines_held = out_lines_reg;

endmodule
`default_nettype wire

[hw/rtl/line_counting_byte_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// Path: a write's response word is registered through the command queue and the
// response register; a read or line read's first byte also passes the store read register.
// Throughput: one byte per cycle during a read while the response is not stalled,
// set by the single read port of the byte store.
// Reset: positions, newline count, queue and response valid clear at once;
// store contents stay undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
// line_counting_byte_fifo: circular byte FIFO with a count of held newlines
// Writes push one byte (or are dropped when the store is full), reads pop up
// to a burst of bytes, and line reads pop through the first newline or, when
// none is found within the burst, only peek at the front bytes.
// ----------------------------------------------------------------------------
module line_counting_byte_fifo #(
    parameter int STORE_SLOTS = lcbf_pkg::STORE_SLOTS_DEF,
    parameter int MAX_BURST   = lcbf_pkg::MAX_BURST_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lcbf_req_if.sink    req,
    lcbf_rsp_if.source  rsp
);
    import lcbf_pkg::*;

    // Decoded commands flow front -> queue -> back; the queue lets the request
    // side keep accepting words while the back end is busy with a burst.
    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic head_valid;

    // The front end decodes each request word and drops words that would
    // produce no response, such as reserved opcodes and zero-length reads.
    lcbf_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (front_cmd)
    );

    lcbf_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // The back end owns the store, the positions and the newline count; a command leaves the queue
    // only when the response register can take its first word.
    lcbf_back #(
        .STORE_SLOTS (STORE_SLOTS),
        .MAX_BURST   (MAX_BURST)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

[hw/rtl/lcbf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcbf_checker: port-level checks for the line-counting byte FIFO
// Watches the response channel and is bound to the top level.
// ----------------------------------------------------------------------------
module lcbf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [lcbf_pkg::BYTE_W-1:0] rsp_byte,
    input logic [lcbf_pkg::STAT_W-1:0] rsp_status,
    input logic                       rsp_last,
    input logic                       rsp_taken
);
    import lcbf_pkg::*;

    // A stalled response word stays offered.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response valid dropped while stalled");

    // A stalled response word keeps its byte and status.
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_byte) && $stable(rsp_status))
        else $error("response payload changed while stalled");

    // A committed line always ends on the newline byte.
    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_taken |->
            rsp_last && rsp_byte == NEWLINE_BYTE && rsp_status == ST_GIVEN)
        else $error("line taken on a word that is not a final newline");

    // Status words stand alone and carry no byte.
    a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_GIVEN |->
            rsp_last && !rsp_taken && rsp_byte == '0)
        else $error("status word carries data or is not final");

endmodule

bind line_counting_byte_fifo lcbf_checker u_lcbf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_byte   (rsp.read_byte),
    .rsp_status (rsp.status),
    .rsp_last   (rsp.last),
    .rsp_taken  (rsp.line_taken)
);
`default_nettype wire
